>>> rtl/tss_pkg.sv
// Shared types and constants for the triangle scanline span block.
package tss_pkg;

  localparam int unsigned CoordW     = 16;
  localparam int unsigned LenW       = CoordW + 1;
  localparam int unsigned NumW       = 2 * CoordW;
  localparam int unsigned DenW       = CoordW;
  localparam int unsigned BitsPerStg = 4;
  localparam int unsigned DivStages  = NumW / BitsPerStg;

  typedef logic signed [CoordW-1:0] coord_t;

  // Sideband that travels alongside the divider pipeline.
  typedef struct packed {
    logic   valid;
    logic   in_range;
    logic   flat;
    logic   neg_a;
    logic   neg_b;
    logic   dyz_a;
    logic   dyz_b;
    coord_t xs_a;
    coord_t xs_b;
    coord_t xmin;
    coord_t xmax;
  } side_t;

endpackage

>>> rtl/tss_div.sv
// Pipelined unsigned restoring divider, a fixed number of quotient bits per stage.
module tss_div #(
  parameter int unsigned NumW       = tss_pkg::NumW,
  parameter int unsigned DenW       = tss_pkg::DenW,
  parameter int unsigned BitsPerStg = tss_pkg::BitsPerStg
) (
  input  logic            clk_i,
  input  logic [NumW-1:0] num_i,
  input  logic [DenW-1:0] den_i,
  output logic [NumW-1:0] quo_o
);

  localparam int unsigned Stages = NumW / BitsPerStg;
  localparam int unsigned RemW   = DenW + 1;

  logic [RemW-1:0] rem_w [0:Stages];
  logic [NumW-1:0] num_w [0:Stages];
  logic [NumW-1:0] quo_w [0:Stages];
  logic [DenW-1:0] den_w [0:Stages];

  assign rem_w[0] = '0;
  assign num_w[0] = num_i;
  assign quo_w[0] = '0;
  assign den_w[0] = den_i;

  for (genvar s = 0; s < Stages; s++) begin : g_stage
    logic [RemW-1:0] rem_d, rem_q;
    logic [NumW-1:0] num_d, num_q;
    logic [NumW-1:0] quo_d, quo_q;
    logic [DenW-1:0] den_q;

    always_comb begin
      rem_d = rem_w[s];
      num_d = num_w[s];
      quo_d = quo_w[s];
      for (int k = 0; k < BitsPerStg; k++) begin
        rem_d = {rem_d[RemW-2:0], num_d[NumW-1]};
        num_d = {num_d[NumW-2:0], 1'b0};
        quo_d = {quo_d[NumW-2:0], 1'b0};
        if (rem_d >= {1'b0, den_w[s]}) begin
          rem_d    = rem_d - {1'b0, den_w[s]};
          quo_d[0] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q <= rem_d;
      num_q <= num_d;
      quo_q <= quo_d;
      den_q <= den_w[s];
    end

    assign rem_w[s+1] = rem_q;
    assign num_w[s+1] = num_q;
    assign quo_w[s+1] = quo_q;
    assign den_w[s+1] = den_q;
  end

  assign quo_o = quo_w[Stages];

endmodule

>>> rtl/triangle_scanline_span_top.sv
// Triangle scanline span: top level with sort, edge setup, multiply and final ordering.
//
// Takes one request per clock cycle; busy_o never rises. The result for a request
// appears on the span ports with done_o high after the start_i transfer has passed
// through registered steps that sort the vertices, set up the edges, multiply, run
// the divider stages (four quotient bits per stage), form the crossings, and
// order them and compute the length. Rows outside the triangle return
// span_valid_o low with zero start and length. The receiver takes every result.
module triangle_scanline_span_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  output logic                              busy_o,
  input  logic signed [tss_pkg::CoordW-1:0] vert0_x_i,
  input  logic signed [tss_pkg::CoordW-1:0] vert0_y_i,
  input  logic signed [tss_pkg::CoordW-1:0] vert1_x_i,
  input  logic signed [tss_pkg::CoordW-1:0] vert1_y_i,
  input  logic signed [tss_pkg::CoordW-1:0] vert2_x_i,
  input  logic signed [tss_pkg::CoordW-1:0] vert2_y_i,
  input  logic signed [tss_pkg::CoordW-1:0] row_i,
  output logic                              done_o,
  output logic                              span_valid_o,
  output logic signed [tss_pkg::CoordW-1:0] span_start_o,
  output logic        [tss_pkg::LenW-1:0]   span_length_o
);

  localparam int unsigned W  = tss_pkg::CoordW;
  localparam int unsigned NW = tss_pkg::NumW;
  localparam int unsigned NS = tss_pkg::DivStages;

  assign busy_o = 1'b0;

  // ---- stage 1: sort by y
  tss_pkg::coord_t xs_c [3];
  tss_pkg::coord_t ys_c [3];
  tss_pkg::coord_t t_c;
  tss_pkg::coord_t x1_q [3];
  tss_pkg::coord_t y1_q [3];
  tss_pkg::coord_t r1_q;
  logic            v1_q;

  always_comb begin
    t_c = '0;
    xs_c[0] = vert0_x_i; ys_c[0] = vert0_y_i;
    xs_c[1] = vert1_x_i; ys_c[1] = vert1_y_i;
    xs_c[2] = vert2_x_i; ys_c[2] = vert2_y_i;
    if (ys_c[0] > ys_c[1]) begin
      t_c = ys_c[0]; ys_c[0] = ys_c[1]; ys_c[1] = t_c;
      t_c = xs_c[0]; xs_c[0] = xs_c[1]; xs_c[1] = t_c;
    end
    if (ys_c[1] > ys_c[2]) begin
      t_c = ys_c[1]; ys_c[1] = ys_c[2]; ys_c[2] = t_c;
      t_c = xs_c[1]; xs_c[1] = xs_c[2]; xs_c[2] = t_c;
    end
    if (ys_c[0] > ys_c[1]) begin
      t_c = ys_c[0]; ys_c[0] = ys_c[1]; ys_c[1] = t_c;
      t_c = xs_c[0]; xs_c[0] = xs_c[1]; xs_c[1] = t_c;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v1_q <= 1'b0;
    else         v1_q <= start_i;
  end

  always_ff @(posedge clk_i) begin
    x1_q <= xs_c;
    y1_q <= ys_c;
    r1_q <= row_i;
  end

  // ---- stage 2: edge setup
  tss_pkg::coord_t xsa_c, ysa_c, xea_c, yea_c;
  logic [W-1:0]    dxa_c, dya_c, dxb_c, dyb_c;
  logic [W:0]      rela_c, relb_c;
  tss_pkg::coord_t mn_c, mx_c;
  tss_pkg::side_t  s2_d, s2_q;
  logic [W-1:0]    adxa_q, adya_q, rela_q, adxb_q, adyb_q, relb_q;

  always_comb begin
    if (r1_q < y1_q[1] || y1_q[1] == y1_q[2]) begin
      xsa_c = x1_q[0]; ysa_c = y1_q[0]; xea_c = x1_q[1]; yea_c = y1_q[1];
    end else begin
      xsa_c = x1_q[1]; ysa_c = y1_q[1]; xea_c = x1_q[2]; yea_c = y1_q[2];
    end
    dxa_c  = xea_c - xsa_c;
    dya_c  = yea_c - ysa_c;
    dxb_c  = x1_q[2] - x1_q[0];
    dyb_c  = y1_q[2] - y1_q[0];
    rela_c = {r1_q[W-1], r1_q} - {ysa_c[W-1], ysa_c};
    relb_c = {r1_q[W-1], r1_q} - {y1_q[0][W-1], y1_q[0]};
    mn_c = x1_q[0];
    mx_c = x1_q[0];
    if (x1_q[1] < mn_c) mn_c = x1_q[1];
    if (x1_q[1] > mx_c) mx_c = x1_q[1];
    if (x1_q[2] < mn_c) mn_c = x1_q[2];
    if (x1_q[2] > mx_c) mx_c = x1_q[2];
    s2_d.valid    = v1_q;
    s2_d.in_range = !(r1_q < y1_q[0] || r1_q > y1_q[2]);
    s2_d.flat     = (y1_q[0] == y1_q[2]);
    s2_d.neg_a    = dxa_c[W-1] ^ dya_c[W-1];
    s2_d.neg_b    = dxb_c[W-1] ^ dyb_c[W-1];
    s2_d.dyz_a    = (dya_c == '0);
    s2_d.dyz_b    = (dyb_c == '0);
    s2_d.xs_a     = xsa_c;
    s2_d.xs_b     = x1_q[0];
    s2_d.xmin     = mn_c;
    s2_d.xmax     = mx_c;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s2_q <= '0;
    else         s2_q <= s2_d;
  end

  always_ff @(posedge clk_i) begin
    adxa_q <= dxa_c[W-1] ? W'(-dxa_c) : dxa_c;
    adya_q <= dya_c[W-1] ? W'(-dya_c) : dya_c;
    adxb_q <= dxb_c[W-1] ? W'(-dxb_c) : dxb_c;
    adyb_q <= dyb_c[W-1] ? W'(-dyb_c) : dyb_c;
    rela_q <= rela_c[W-1:0];
    relb_q <= relb_c[W-1:0];
  end

  // ---- stage 3: multiply magnitudes
  tss_pkg::side_t          s3_q;
  logic [NW-1:0]           pa_q, pb_q;
  logic [W-1:0]            dena_q, denb_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s3_q <= '0;
    else         s3_q <= s2_q;
  end

  always_ff @(posedge clk_i) begin
    pa_q   <= NW'(adxa_q) * NW'(rela_q);
    pb_q   <= NW'(adxb_q) * NW'(relb_q);
    dena_q <= adya_q;
    denb_q <= adyb_q;
  end

  // ---- divider stages, sideband delayed alongside
  logic [NW-1:0]            qa_w, qb_w;
  tss_pkg::side_t           sd_q [NS];

  tss_div #(
    .NumW(tss_pkg::NumW), .DenW(tss_pkg::DenW), .BitsPerStg(tss_pkg::BitsPerStg)
  ) u_div_a (.clk_i(clk_i), .num_i(pa_q), .den_i(dena_q), .quo_o(qa_w));
  tss_div #(
    .NumW(tss_pkg::NumW), .DenW(tss_pkg::DenW), .BitsPerStg(tss_pkg::BitsPerStg)
  ) u_div_b (.clk_i(clk_i), .num_i(pb_q), .den_i(denb_q), .quo_o(qb_w));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NS; i++) sd_q[i] <= '0;
    end else begin
      sd_q[0] <= s3_q;
      for (int i = 1; i < NS; i++) sd_q[i] <= sd_q[i-1];
    end
  end

  // ---- final stage 1: signed quotient plus start x, wrapped; flat triangles use x min/max
  tss_pkg::side_t  sl_c;
  logic [W-1:0]    qa16_c, qb16_c;
  tss_pkg::coord_t ca_d, cb_d, ca_q, cb_q;
  logic            f1_v_q, f1_in_q;

  always_comb begin
    sl_c   = sd_q[NS-1];
    qa16_c = sl_c.neg_a ? W'(-qa_w[W-1:0]) : qa_w[W-1:0];
    qb16_c = sl_c.neg_b ? W'(-qb_w[W-1:0]) : qb_w[W-1:0];
    if (sl_c.flat) begin
      ca_d = sl_c.xmin;
      cb_d = sl_c.xmax;
    end else begin
      ca_d = sl_c.dyz_a ? sl_c.xs_a : sl_c.xs_a + qa16_c;
      cb_d = sl_c.dyz_b ? sl_c.xs_b : sl_c.xs_b + qb16_c;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) f1_v_q <= 1'b0;
    else         f1_v_q <= sl_c.valid;
  end

  always_ff @(posedge clk_i) begin
    f1_in_q <= sl_c.in_range;
    ca_q    <= ca_d;
    cb_q    <= cb_d;
  end

  // ---- final stage 2: order crossings, form length
  tss_pkg::coord_t lo_c, hi_c;
  logic [W:0]      len_c;

  always_comb begin
    if (ca_q > cb_q) begin
      lo_c = cb_q; hi_c = ca_q;
    end else begin
      lo_c = ca_q; hi_c = cb_q;
    end
    len_c = {hi_c[W-1], hi_c} - {lo_c[W-1], lo_c} + (W+1)'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) done_o <= 1'b0;
    else         done_o <= f1_v_q;
  end

  always_ff @(posedge clk_i) begin
    span_valid_o  <= f1_in_q;
    span_start_o  <= f1_in_q ? lo_c : '0;
    span_length_o <= f1_in_q ? len_c : '0;
  end

`ifndef NO_ASSERTIONS
  a_empty_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !span_valid_o |-> span_start_o == '0 && span_length_o == '0)
    else $error("row outside triangle carries a span");
  a_len_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && span_valid_o |-> span_length_o != '0)
    else $error("valid span has zero length");
  a_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    f1_v_q |=> done_o)
    else $error("result dropped in final stage");
`endif

endmodule
